[design/lfu_nlc_pkg.sv]
package lfu_nlc_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 64;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = $clog2(ENTRIES);

  typedef struct packed {
    logic [63:0] lookup_key;
    logic        directory_found;
    logic [31:0] directory_value;
  } req_t;

  typedef struct packed {
    logic        found;
    logic        was_hit;
    logic [31:0] result_value;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  // low 32 bits of a stored value, zero-extended when the value is narrower
  function automatic logic [31:0] to_result(input logic [VALUE_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

endpackage

[design/lfu_name_lookup_cache.sv]
// Least-frequently-used lookup cache, fully associative.
// Request channel (req_valid/req_ready/req): a key plus the backing
// directory's answer for it. Response channel (rsp_valid/rsp_ready/rsp):
// exactly one transaction per request, in request order.
// Entries live in one synchronous RAM (key, value, use count) with registered
// read data; a bit per entry marks it written.
// A scan reads one entry per cycle and compares the previous read.
// A hit ends the scan early; a miss scans every entry. Then comes a write-back
// (skipped on a not-found miss) and the load of the response register;
// req_ready returns in the same cycle as rsp_valid rises.
// One request is in flight at a time; req_ready is high only when idle.
// The response register lets the next request be taken while a finished
// response still waits for rsp_ready. If the receiver stalls with the
// register full, the finished request waits in the done state.
// Reset clears the entry-written bits (all counts read as zero), the
// state machine and rsp_valid; key and value contents are not cleared.
module lfu_name_lookup_cache
  import lfu_nlc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t state, state_next;

  entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] live;

  logic [KEY_BITS-1:0]   key_q;
  logic                  dir_found_q;
  logic [VALUE_BITS-1:0] dir_value_q;

  logic [IDX_W-1:0] rd_idx;
  logic             rd_on;
  logic [IDX_W-1:0] chk_idx;
  logic             chk_vld;
  entry_t           rd_ent;
  logic             rd_live;

  logic [COUNT_BITS-1:0] least;
  logic [IDX_W-1:0]      victim;

  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_ent;
  logic             wr_fill;
  rsp_t             res;

  logic                  req_acc;
  logic                  mem_re;
  logic                  mem_we;
  logic                  hit;
  logic                  last_chk;
  logic [COUNT_BITS-1:0] eff_count;
  logic                  take_min;
  logic [COUNT_BITS-1:0] least_sel;
  logic [IDX_W-1:0]      victim_sel;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  rsp_load;

  assign req_acc   = req_valid && req_ready;
  assign eff_count = rd_live ? rd_ent.count : '0;
  assign hit       = chk_vld && rd_live && (rd_ent.key == key_q);
  assign last_chk  = chk_vld && (chk_idx == IDX_W'(ENTRIES - 1));
  assign take_min  = (chk_idx == '0) || (eff_count < least);
  assign least_sel = take_min ? eff_count : least;
  assign victim_sel = take_min ? chk_idx : victim;
  assign count_inc = (rd_ent.count == '1) ? rd_ent.count : rd_ent.count + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_acc) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit) state_next = ST_WRITE;
        else if (last_chk) state_next = dir_found_q ? ST_WRITE : ST_DONE;
      end
      ST_WRITE: state_next = ST_DONE;
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    req_ready = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    rsp_load  = 1'b0;
    case (state)
      ST_IDLE:  req_ready = 1'b1;
      ST_SCAN:  mem_re    = rd_on && !hit;
      ST_WRITE: mem_we    = 1'b1;
      ST_DONE:  rsp_load  = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      live      <= '0;
      rd_on     <= 1'b0;
      chk_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (req_acc) begin
        rd_on <= 1'b1;
      end else if (mem_re && rd_idx == IDX_W'(ENTRIES - 1)) begin
        rd_on <= 1'b0;
      end else if (hit) begin
        rd_on <= 1'b0;
      end
      chk_vld <= mem_re;
      if (mem_we && wr_fill) live[wr_idx] <= 1'b1;
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // RAM: one read port with registered data, one write port
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_ent  <= mem[rd_idx];
      rd_live <= live[rd_idx];
    end
    if (mem_we) mem[wr_idx] <= wr_ent;
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      key_q       <= req.lookup_key[KEY_BITS-1:0];
      dir_found_q <= req.directory_found;
      dir_value_q <= VALUE_BITS'(req.directory_value);
      rd_idx      <= '0;
    end else if (mem_re) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (mem_re) chk_idx <= rd_idx;

    if (state == ST_SCAN && chk_vld) begin
      least  <= least_sel;
      victim <= victim_sel;
      if (hit) begin
        wr_idx           <= chk_idx;
        wr_ent           <= '{key: rd_ent.key, value: rd_ent.value, count: count_inc};
        wr_fill          <= 1'b0;
        res.found        <= 1'b1;
        res.was_hit      <= 1'b1;
        res.result_value <= to_result(rd_ent.value);
      end else if (last_chk) begin
        wr_idx           <= victim_sel;
        wr_ent           <= '{key: key_q, value: dir_value_q, count: COUNT_BITS'(1)};
        wr_fill          <= 1'b1;
        res.found        <= dir_found_q;
        res.was_hit      <= 1'b0;
        res.result_value <= dir_found_q ? to_result(dir_value_q) : 32'd0;
      end
    end

    if (rsp_load) rsp <= res;
  end

endmodule

[design/lfu_nlc_checker.sv]
module lfu_nlc_checker
  import lfu_nlc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // a null result carries no handle
  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.result_value == 32'd0)
    else $error("not-found response with nonzero value");

  a_hit_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.was_hit |-> rsp.found)
    else $error("hit response without found");

  // one request in flight: no new transaction right after one is taken
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

endmodule

bind lfu_name_lookup_cache lfu_nlc_checker u_lfu_nlc_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import lfu_nlc_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;

  // Tracks the cache contents and the responses still owed by the block.
  class lfu_cache_checker;
    logic [KEY_BITS-1:0]   slot_key[ENTRIES];
    logic [VALUE_BITS-1:0] slot_value[ENTRIES];
    logic [COUNT_BITS-1:0] slot_uses[ENTRIES];
    rsp_t                  owed_rsp[$];
    int                    errors;

    function void clear();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_uses[i]  = '0;
      end
      owed_rsp.delete();
      errors = 0;
    endfunction

    function rsp_t predict_lookup(req_t r);
      logic [KEY_BITS-1:0]   k;
      logic [VALUE_BITS-1:0] v;
      logic [COUNT_BITS-1:0] least;
      int                    victim;
      rsp_t                  o;
      k      = r.lookup_key[KEY_BITS-1:0];
      v      = r.directory_value[VALUE_BITS-1:0];
      victim = 0;
      least  = slot_uses[0];
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_uses[i] < least) begin
          least  = slot_uses[i];
          victim = i;
        end
        if (slot_uses[i] != '0 && slot_key[i] == k) begin
          if (slot_uses[i] != '1) slot_uses[i]++;
          o.found        = 1'b1;
          o.was_hit      = 1'b1;
          o.result_value = 32'(slot_value[i]);
          return o;
        end
      end
      o = '0;
      if (!r.directory_found) return o;
      slot_key[victim]   = k;
      slot_value[victim] = v;
      slot_uses[victim]  = COUNT_BITS'(1);
      o.found        = 1'b1;
      o.result_value = 32'(v);
      return o;
    endfunction

    function void note_request(req_t r);
      owed_rsp.push_back(predict_lookup(r));
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (owed_rsp.size() == 0) begin
        $display("%0t: response with none outstanding, actual %h", $time, got);
        errors++;
        return;
      end
      exp = owed_rsp.pop_front();
      if (got.found !== exp.found) begin
        $display("%0t: found expected %0b actual %0b", $time, exp.found, got.found);
        errors++;
      end
      if (got.was_hit !== exp.was_hit) begin
        $display("%0t: was_hit expected %0b actual %0b", $time, exp.was_hit, got.was_hit);
        errors++;
      end
      if (got.result_value !== exp.result_value) begin
        $display("%0t: result_value expected %h actual %h", $time,
                 exp.result_value, got.result_value);
        errors++;
      end
    endfunction

    function int pending();
      return owed_rsp.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  lfu_cache_checker sb = new;

  bit          tx_idle_on;
  bit          rx_stall_on;
  int          stall_left;
  int          cycles;
  logic [63:0] key_pool[64];
  int          pool_size;

  lfu_name_lookup_cache u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short pauses, now and then a long one
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_ready <= 1'b1;
      if (rx_stall_on && $urandom_range(0, 3) == 0) stall_left = pick_pause();
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic req_t mk_req(logic [63:0] k, logic f, logic [31:0] v);
    req_t r;
    r.lookup_key      = k;
    r.directory_found = f;
    r.directory_value = v;
    return r;
  endfunction

  // valid is left high when no pause follows, so back-to-back items never drop it
  task automatic send_req(input req_t r);
    int gap;
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
    gap = tx_idle_on ? pick_pause() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly repeats from a small key set so hits and evictions dominate
  function automatic req_t rand_req();
    logic [63:0] k;
    logic        f;
    int          r;
    r = $urandom_range(0, 99);
    k = key_pool[$urandom_range(0, pool_size - 1)];
    f = ($urandom_range(0, 9) != 0);
    if (r >= 85) begin
      k = {$urandom, $urandom};
      f = 1'($urandom_range(0, 1));
    end else if (r >= 70) begin
      k = k ^ (64'h1 << $urandom_range(0, 63));
      f = 1'($urandom_range(0, 1));
    end
    return mk_req(k, f, rand_value());
  endfunction

  task automatic run_phase(input int n, input int psize, input bit tx_on, input bit rx_on);
    pool_size   = psize;
    tx_idle_on  = tx_on;
    rx_stall_on = rx_on;
    for (int i = 0; i < psize; i++) key_pool[i] = {$urandom, $urandom};
    repeat (n) send_req(rand_req());
    drain();
  endtask

  initial begin
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    rsp_ready   = 1'b0;
    stall_left  = 0;
    cycles      = 0;
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    sb.clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty cache, extremes, hit, not-found, fill and tie-break eviction
    send_req(mk_req(64'h0, 1'b0, 32'h1234_5678));
    send_req(mk_req(64'h0, 1'b1, 32'hFFFF_FFFF));
    send_req(mk_req(64'h0, 1'b1, 32'h0));
    send_req(mk_req('1, 1'b1, 32'h0));
    send_req(mk_req('1, 1'b0, 32'hFFFF_FFFF));
    send_req(mk_req(64'h8000_0000_0000_0000, 1'b0, 32'hFFFF_FFFF));
    send_req(mk_req(64'h1, 1'b1, 32'h1));
    send_req(mk_req(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 32'h8000_0000));
    for (int i = 0; i < ENTRIES - 4; i++)
      send_req(mk_req(64'h1 << (i * 5 + 3), 1'b1, $urandom));
    send_req(mk_req(64'hDEAD_BEEF_0BAD_F00D, 1'b1, 32'h5A5A_A5A5));
    send_req(mk_req(64'h1, 1'b0, 32'h7));
    send_req(mk_req(64'h1, 1'b1, 32'h9));
    send_req(mk_req(64'h0, 1'b0, 32'h0));
    drain();

    // pile hits on the slot of key 0, then check it survives a miss
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    repeat (40) send_req(mk_req(64'h0, 1'b0, $urandom));
    send_req(mk_req(64'hC0FF_EE00_1234_5678, 1'b1, $urandom));
    send_req(mk_req(64'h0, 1'b1, $urandom));
    drain();

    run_phase(300, 8, 1'b1, 1'b1);
    run_phase(300, 24, 1'b1, 1'b0);
    run_phase(250, 48, 1'b0, 1'b1);
    run_phase(150, 16, 1'b0, 1'b0);
    run_phase(100, 20, 1'b1, 1'b1);

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
